FILE: rtl/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

  // parser phase, one code per expected field of a frame
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_TAIL1 = 3'd6,
    PH_TAIL2 = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_SUM = 2'd2,
    KIND_FAULT   = 2'd3
  } kind_t;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned MAX_LEN_BITS = 7;

  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAIL_FIRST  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAIL_SECOND = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_COMMAND = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LENGTH  = 3'd5;

  localparam logic [7:0] RST_SYNC_FIRST  = 8'hFC;
  localparam logic [7:0] RST_SYNC_SECOND = 8'hFF;
  localparam logic [7:0] RST_TAIL_FIRST  = 8'hA1;
  localparam logic [7:0] RST_TAIL_SECOND = 8'hA2;
  localparam logic [7:0] RST_MAX_COMMAND = 8'hF0;
  localparam logic [MAX_LEN_BITS-1:0] RST_MAX_LENGTH = 7'd99;

endpackage

`default_nettype wire

FILE: rtl/serial_frame_deframer_xor_check.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_rx_byte
// out_      output     out_valid / out_stall kind, command, frame_length, byte_index,
//                                            payload_byte, fault_count
// cfg_      input      cfg_wr_en             cfg_index, cfg_data
//
// One byte per cycle sustained while the result is not stalled. A byte is captured in the input
// register, parsed by the phase logic and, if it gives a result, lands in the result register.
// Bytes that give no result still pass through the parse stage in order.
// rst_n is synchronous; it clears parser state and loads the register defaults.
// A stalled result holds the parse stage; the input register then fills and
// in_stall rises.

module serial_frame_deframer_xor_check #(
  parameter int unsigned LENGTH_BITS = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         in_rx_byte,

  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_kind,
  output logic [7:0]                              out_command,
  output logic [LENGTH_BITS-1:0]                  out_frame_length,
  output logic [LENGTH_BITS-1:0]                  out_byte_index,
  output logic [7:0]                              out_payload_byte,
  output logic [31:0]                             out_fault_count,

  input  wire logic                               cfg_wr_en,
  input  wire logic [sfd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [sfd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration registers
  logic [7:0] sync_first_r, sync_second_r, tail_first_r, tail_second_r, max_command_r;
  logic [sfd_pkg::MAX_LEN_BITS-1:0] max_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= sfd_pkg::RST_SYNC_FIRST;
      sync_second_r <= sfd_pkg::RST_SYNC_SECOND;
      tail_first_r  <= sfd_pkg::RST_TAIL_FIRST;
      tail_second_r <= sfd_pkg::RST_TAIL_SECOND;
      max_command_r <= sfd_pkg::RST_MAX_COMMAND;
      max_length_r  <= sfd_pkg::RST_MAX_LENGTH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sfd_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        sfd_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_data;
        sfd_pkg::REG_TAIL_FIRST:  tail_first_r  <= cfg_data;
        sfd_pkg::REG_TAIL_SECOND: tail_second_r <= cfg_data;
        sfd_pkg::REG_MAX_COMMAND: max_command_r <= cfg_data;
        sfd_pkg::REG_MAX_LENGTH:  max_length_r  <= cfg_data[sfd_pkg::MAX_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       parse_go;

  assign parse_go = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !parse_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // parser state
  sfd_pkg::phase_t          phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]   remaining_r, remaining_nxt;
  logic [LENGTH_BITS-1:0]   index_r, index_nxt;
  logic [7:0]               xor_r, xor_nxt;
  logic [7:0]               check_r, check_nxt;
  logic [7:0]               command_r, command_nxt;
  logic [LENGTH_BITS-1:0]   length_r, length_nxt;
  logic [31:0]              faults_r, faults_nxt;

  logic                     res_vld;
  sfd_pkg::kind_t           res_kind;
  logic [LENGTH_BITS-1:0]   res_index;
  logic [7:0]               res_byte;
  logic [LENGTH_BITS-1:0]   rem_dec;
  logic [7:0]               b;

  assign b       = in_byte_r;
  assign rem_dec = remaining_r - LENGTH_BITS'(1);

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    index_nxt     = index_r;
    xor_nxt       = xor_r;
    check_nxt     = check_r;
    command_nxt   = command_r;
    length_nxt    = length_r;
    faults_nxt    = faults_r;
    res_vld       = 1'b0;
    res_kind      = sfd_pkg::KIND_FAULT;
    res_index     = '0;
    res_byte      = '0;

    if (phase_r == sfd_pkg::PH_IDLE && b == sync_first_r) begin
      phase_nxt = sfd_pkg::PH_SYNC2;
      xor_nxt   = b;
    end else if (phase_r == sfd_pkg::PH_SYNC2 && b == sync_second_r) begin
      phase_nxt = sfd_pkg::PH_CMD;
      xor_nxt   = xor_r ^ b;
    end else if (phase_r == sfd_pkg::PH_CMD && b <= max_command_r) begin
      phase_nxt   = sfd_pkg::PH_LEN;
      command_nxt = b;
      xor_nxt     = xor_r ^ b;
    end else if (phase_r == sfd_pkg::PH_LEN && b <= {1'b0, max_length_r}) begin
      phase_nxt     = sfd_pkg::PH_DATA;
      length_nxt    = b[LENGTH_BITS-1:0];
      remaining_nxt = b[LENGTH_BITS-1:0];
      index_nxt     = '0;
      xor_nxt       = xor_r ^ b;
    end else if (phase_r == sfd_pkg::PH_DATA && remaining_r != '0) begin
      xor_nxt       = xor_r ^ b;
      index_nxt     = index_r + LENGTH_BITS'(1);
      remaining_nxt = rem_dec;
      if (rem_dec == '0) begin
        phase_nxt = sfd_pkg::PH_CHECK;
      end
      res_vld   = 1'b1;
      res_kind  = sfd_pkg::KIND_PAYLOAD;
      res_index = index_r;
      res_byte  = b;
    end else if (phase_r == sfd_pkg::PH_CHECK) begin
      phase_nxt = sfd_pkg::PH_TAIL1;
      check_nxt = b;
    end else if (phase_r == sfd_pkg::PH_TAIL1 && b == tail_first_r) begin
      phase_nxt = sfd_pkg::PH_TAIL2;
    end else if (phase_r == sfd_pkg::PH_TAIL2 && b == tail_second_r) begin
      phase_nxt = sfd_pkg::PH_IDLE;
      res_vld   = 1'b1;
      res_kind  = (xor_r == check_r) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD_SUM;
    end else begin
      // framing fault: back to hunting for the first sync byte
      phase_nxt  = sfd_pkg::PH_IDLE;
      faults_nxt = faults_r + 32'd1;
      res_vld    = 1'b1;
      res_kind   = sfd_pkg::KIND_FAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfd_pkg::PH_IDLE;
      remaining_r <= '0;
      index_r     <= '0;
      xor_r       <= '0;
      check_r     <= '0;
      command_r   <= '0;
      length_r    <= '0;
      faults_r    <= '0;
    end else if (parse_go) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      index_r     <= index_nxt;
      xor_r       <= xor_nxt;
      check_r     <= check_nxt;
      command_r   <= command_nxt;
      length_r    <= length_nxt;
      faults_r    <= faults_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= parse_go && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (parse_go && res_vld) begin
      out_kind         <= res_kind;
      out_command      <= command_r;
      out_frame_length <= length_r;
      out_byte_index   <= res_index;
      out_payload_byte <= res_byte;
      out_fault_count  <= faults_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/serial_frame_deframer_xor_check_test.sv
`default_nettype none

module serial_frame_deframer_xor_check_test;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;
  // indexes past the last register; writes there must be ignored
  localparam logic [sfd_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [sfd_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    sfd_pkg::kind_t                   kind;
    logic [7:0]                       command;
    logic [sfd_pkg::MAX_LEN_BITS-1:0] frame_length;
    logic [sfd_pkg::MAX_LEN_BITS-1:0] byte_index;
    logic [7:0]                       payload_byte;
    logic [31:0]                      fault_count;
  } frame_result_t;

  class deframer_tracker;
    // register mirror
    logic [7:0]                       sync_a, sync_b, tail_a, tail_b, max_cmd;
    logic [sfd_pkg::MAX_LEN_BITS-1:0] max_len;
    // parser mirror
    sfd_pkg::phase_t                  stage;
    logic [sfd_pkg::MAX_LEN_BITS-1:0] left, index, cur_len;
    logic [7:0]                       xor_acc, rx_sum, cur_cmd;
    logic [31:0]                      faults;

    frame_result_t           due_results[$];
    int unsigned             errors;
    int unsigned             kind_seen[4];

    function new();
      sync_a  = sfd_pkg::RST_SYNC_FIRST;
      sync_b  = sfd_pkg::RST_SYNC_SECOND;
      tail_a  = sfd_pkg::RST_TAIL_FIRST;
      tail_b  = sfd_pkg::RST_TAIL_SECOND;
      max_cmd = sfd_pkg::RST_MAX_COMMAND;
      max_len = sfd_pkg::RST_MAX_LENGTH;
      stage   = sfd_pkg::PH_IDLE;
      left    = '0;
      index   = '0;
      cur_len = '0;
      xor_acc = '0;
      rx_sum  = '0;
      cur_cmd = '0;
      faults  = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [sfd_pkg::CFG_IDX_BITS-1:0] idx, logic [7:0] data);
      case (idx)
        sfd_pkg::REG_SYNC_FIRST:  sync_a = data;
        sfd_pkg::REG_SYNC_SECOND: sync_b = data;
        sfd_pkg::REG_TAIL_FIRST:  tail_a = data;
        sfd_pkg::REG_TAIL_SECOND: tail_b = data;
        sfd_pkg::REG_MAX_COMMAND: max_cmd = data;
        sfd_pkg::REG_MAX_LENGTH:  max_len = data[sfd_pkg::MAX_LEN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void push(sfd_pkg::kind_t k, logic [sfd_pkg::MAX_LEN_BITS-1:0] idx,
                       logic [7:0] val);
      frame_result_t r;
      r.kind         = k;
      r.command      = cur_cmd;
      r.frame_length = cur_len;
      r.byte_index   = idx;
      r.payload_byte = val;
      r.fault_count  = faults;
      due_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [sfd_pkg::MAX_LEN_BITS-1:0] idx;
      if (stage == sfd_pkg::PH_IDLE && b == sync_a) begin
        stage   = sfd_pkg::PH_SYNC2;
        xor_acc = b;
      end else if (stage == sfd_pkg::PH_SYNC2 && b == sync_b) begin
        stage   = sfd_pkg::PH_CMD;
        xor_acc ^= b;
      end else if (stage == sfd_pkg::PH_CMD && b <= max_cmd) begin
        stage   = sfd_pkg::PH_LEN;
        cur_cmd = b;
        xor_acc ^= b;
      end else if (stage == sfd_pkg::PH_LEN && b <= {1'b0, max_len}) begin
        // the compare sees all 8 bits, so bytes with bit 7 set fail here
        stage   = sfd_pkg::PH_DATA;
        cur_len = b[sfd_pkg::MAX_LEN_BITS-1:0];
        left    = b[sfd_pkg::MAX_LEN_BITS-1:0];
        index   = '0;
        xor_acc ^= b;
      end else if (stage == sfd_pkg::PH_DATA && left != 0) begin
        idx     = index;
        xor_acc ^= b;
        index   = index + 1'b1;
        left    = left - 1'b1;
        if (left == 0) stage = sfd_pkg::PH_CHECK;
        push(sfd_pkg::KIND_PAYLOAD, idx, b);
      end else if (stage == sfd_pkg::PH_CHECK) begin
        stage  = sfd_pkg::PH_TAIL1;
        rx_sum = b;
      end else if (stage == sfd_pkg::PH_TAIL1 && b == tail_a) begin
        stage = sfd_pkg::PH_TAIL2;
      end else if (stage == sfd_pkg::PH_TAIL2 && b == tail_b) begin
        stage = sfd_pkg::PH_IDLE;
        push((xor_acc == rx_sum) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD_SUM, '0, '0);
      end else begin
        // also a zero-length frame hitting its next byte
        stage  = sfd_pkg::PH_IDLE;
        faults = faults + 32'd1;
        push(sfd_pkg::KIND_FAULT, '0, '0);
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_output(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d cmd %0h len %0d",
                 $time, got.kind, got.command, got.frame_length);
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("command", 32'(want.command), 32'(got.command));
        check_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
        check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
        check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        check_field("fault_count", want.fault_count, got.fault_count);
        kind_seen[want.kind]++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       in_rx_byte = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       out_kind;
  logic [7:0]                       out_command;
  logic [sfd_pkg::MAX_LEN_BITS-1:0] out_frame_length;
  logic [sfd_pkg::MAX_LEN_BITS-1:0] out_byte_index;
  logic [7:0]                       out_payload_byte;
  logic [31:0]                      out_fault_count;
  logic                             cfg_wr_en = 1'b0;
  logic [sfd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [7:0]                       cfg_data = '0;

  deframer_tracker sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned quiet_cycles = 0;

  serial_frame_deframer_xor_check i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_command      (out_command),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_fault_count  (out_fault_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.kind         = sfd_pkg::kind_t'(out_kind);
        got.command      = out_command;
        got.frame_length = out_frame_length;
        got.byte_index   = out_byte_index;
        got.payload_byte = out_payload_byte;
        got.fault_count  = out_fault_count;
        sb.check_output(got);
      end
      if (in_valid && !in_stall) sb.take_byte(in_rx_byte);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    // bytes that give no result may still sit in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [7:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [7:0] sa, input logic [7:0] sb2, input logic [7:0] ta,
                           input logic [7:0] tb2, input logic [7:0] mc, input logic [7:0] ml);
    write_reg(sfd_pkg::REG_SYNC_FIRST, sa);
    write_reg(sfd_pkg::REG_SYNC_SECOND, sb2);
    write_reg(sfd_pkg::REG_TAIL_FIRST, ta);
    write_reg(sfd_pkg::REG_TAIL_SECOND, tb2);
    write_reg(sfd_pkg::REG_MAX_COMMAND, mc);
    write_reg(sfd_pkg::REG_MAX_LENGTH, ml);
    write_reg(REG_SPARE_LO, 8'($urandom_range(255, 0)));
    write_reg(REG_SPARE_HI, 8'($urandom_range(255, 0)));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0] frame_bytes[$];
    logic [7:0] cmd, len, sum, b;
    int unsigned cap, pick, pos;
    pick = $urandom_range(9, 0);
    if (pick == 0) cmd = sb.max_cmd;
    else if (pick == 1) cmd = 8'h00;
    else cmd = 8'($urandom_range(sb.max_cmd, 0));
    cap  = (sb.max_len < 12) ? sb.max_len : 12;
    pick = $urandom_range(19, 0);
    if (pick == 0) len = {1'b0, sb.max_len};
    else if (pick <= 2) len = 8'h00;
    else len = 8'($urandom_range(cap, 0));
    frame_bytes = '{sb.sync_a, sb.sync_b, cmd, len};
    sum = sb.sync_a ^ sb.sync_b ^ cmd ^ len;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255, 0));
      sum ^= b;
      frame_bytes.push_back(b);
    end
    if ($urandom_range(3, 0) == 0) sum ^= 8'($urandom_range(255, 1));
    frame_bytes.push_back(sum);
    frame_bytes.push_back(sb.tail_a);
    frame_bytes.push_back(sb.tail_b);
    // break a minority of frames
    pick = $urandom_range(15, 0);
    pos  = $urandom_range(frame_bytes.size() - 1, 0);
    if (pick == 0) begin
      frame_bytes[pos] = 8'($urandom_range(255, 0));
    end else if (pick == 1 && sb.max_cmd != 8'hFF) begin
      frame_bytes[2] = 8'($urandom_range(255, sb.max_cmd + 1));
    end else if (pick == 2) begin
      frame_bytes[3] = 8'($urandom_range(255, sb.max_len + 1));
    end else if (pick == 3) begin
      frame_bytes.delete(pos);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic run_segment(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned budget);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      if ($urandom_range(9, 0) < 2) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255, 0)));
      end
      send_random_frame();
    end
    wait_drained();
  endtask

  initial begin
    // good frame at max command, zero-length frame hit by a misplaced sync,
    // command over its limit, length over its limit
    logic [7:0] directed_bytes[20] = '{
      8'hFC, 8'hFF, 8'hF0, 8'h01, 8'hFF, 8'h0D, 8'hA1, 8'hA2,
      8'hFC, 8'hFF, 8'h00, 8'h00, 8'hFC,
      8'hFC, 8'hFF, 8'hF1,
      8'hFC, 8'hFF, 8'h00, 8'h64
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 12;
    recv_stall_pct = 74;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    run_segment(12, 74, 260);

    // all-ones write to max_length checks masking down to 127
    load_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    run_segment(74, 12, 260);

    load_regs(8'h55, 8'h55, 8'hAA, 8'hAA, 8'h00, 8'h00);
    run_segment(0, 0, 260);

    load_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
              8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
              8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    run_segment(0, 0, 260);

    repeat (10) @(posedge clk);
    $display("Run covered %0d input beats under four register settings and three pacing modes;",
             beats_sent);
    $display("results: %0d payload, %0d good, %0d checksum bad, %0d framing faults",
             sb.kind_seen[sfd_pkg::KIND_PAYLOAD], sb.kind_seen[sfd_pkg::KIND_GOOD],
             sb.kind_seen[sfd_pkg::KIND_BAD_SUM], sb.kind_seen[sfd_pkg::KIND_FAULT]);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
